// ===== hdl/ddgps_pkg.sv =====
`timescale 1ns / 1ps

package ddgps_pkg;

    // Field widths
    localparam int PosW   = 14;
    localparam int HeadW  = 10;
    localparam int DW     = 15;   // position difference
    localparam int AbsW   = 14;   // magnitude of a difference
    localparam int SqW    = 28;
    localparam int D2W    = 30;   // squared distance and root work registers
    localparam int CW     = 34;   // CORDIC x / y
    localparam int AW     = 25;   // CORDIC angle, degrees Q16
    localparam int NW     = 34;   // speed numerator
    localparam int SpeedW = 8;
    localparam int InDataW  = 72;
    localparam int OutDataW = 16;

    localparam int SigDepthDefault = 256;
    localparam int CordicSteps     = 16;
    localparam int SqrtSteps       = 15;

    localparam logic [6:0]  CruiseReset = 7'd70;
    localparam logic [16:0] OffsetQ16   = 17'd19661;   // 0.3 in Q16
    localparam logic [14:0] Recip90     = 15'd23301;   // floor(2^21 / 90)

    // Squared distance thresholds (100, 50, 30, 20 and 5 inches)
    localparam logic [D2W-1:0] D2Band100 = 30'd40960000;
    localparam logic [D2W-1:0] D2Band50  = 30'd10240000;
    localparam logic [D2W-1:0] D2Band30  = 30'd3686400;
    localparam logic [D2W-1:0] D2Band20  = 30'd1638400;
    localparam logic [D2W-1:0] D2Near    = 30'd102400;

    // Turn gains, numerators over 90
    localparam logic [4:0] GainFar   = 5'd17;
    localparam logic [4:0] Gain100   = 5'd19;
    localparam logic [4:0] Gain50    = 5'd21;
    localparam logic [4:0] Gain30    = 5'd23;
    localparam logic [4:0] GainClose = 5'd25;
    localparam logic [4:0] GainNear  = 5'd9;

    // atan(2^-i) in degrees Q16
    localparam logic [22:0] ATAN_Q16 [CordicSteps] = '{
        23'd2949120, 23'd1740967, 23'd919879, 23'd466945,
        23'd234379,  23'd117304,  23'd58666,  23'd29335,
        23'd14668,   23'd7334,    23'd3667,   23'd1833,
        23'd917,     23'd458,     23'd229,    23'd115
    };

    // One transaction inside the CORDIC / square root stages
    typedef struct packed {
        logic signed [CW-1:0]    x;
        logic signed [CW-1:0]    y;
        logic signed [AW-1:0]    a;
        logic [D2W-1:0]          rem;
        logic [D2W-1:0]          root;
        logic [D2W-1:0]          d2;
        logic signed [HeadW-1:0] heading;
        logic                    dx_neg;
        logic                    dy_neg;
        logic                    at_origin;
        logic                    force_a;
        logic [6:0]              forced_deg;
    } iter_t;

    // Sigmoid entry i in Q16, built at elaboration
    function automatic logic [16:0] sig_entry(input int idx);
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] rem;
        logic [46:0] q;
        e = 64'd1 << 30;
        for (int k = 0; k < idx; k++) begin
            e = (e * 64'd1024571606 + (64'd1 << 29)) >> 30;
        end
        den = (64'd1 << 30) + e;
        rem = '0;
        q   = '0;
        // long division of 2^46 by den
        for (int b = 46; b >= 0; b--) begin
            rem = {rem[62:0], (b == 46)};
            if (rem >= den) begin
                rem  = rem - den;
                q[b] = 1'b1;
            end
        end
        return q[16:0];
    endfunction

endpackage

// ===== hdl/ddgps_iter.sv =====
`timescale 1ns / 1ps

// One CORDIC vectoring step and, in the first SqrtSteps stages, one square root digit, registered
module ddgps_iter
    import ddgps_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic  aclk,
    input  logic  en,
    input  iter_t d,
    output iter_t q
);

    localparam bit DoSqrt = (STEP < SqrtSteps);
    localparam int BitPos = DoSqrt ? 2 * (SqrtSteps - 1 - STEP) : 0;
    localparam logic [D2W-1:0] BitV = D2W'(1) << BitPos;

    logic signed [AW-1:0] atan_v;
    logic signed [CW-1:0] sh_x;
    logic signed [CW-1:0] sh_y;
    logic [D2W-1:0]       trial;
    iter_t                nxt;

    assign atan_v = signed'(AW'(ATAN_Q16[STEP]));
    assign sh_x   = d.x >>> STEP;
    assign sh_y   = d.y >>> STEP;
    assign trial  = d.root + BitV;

    always_comb begin
        nxt = d;
        // rotate toward y = 0
        if (d.y > 0) begin
            nxt.x = d.x + sh_y;
            nxt.y = d.y - sh_x;
            nxt.a = d.a + atan_v;
        end else begin
            nxt.x = d.x - sh_y;
            nxt.y = d.y + sh_x;
            nxt.a = d.a - atan_v;
        end
        // integer square root digit
        if (DoSqrt) begin
            if (d.rem >= trial) begin
                nxt.rem  = d.rem - trial;
                nxt.root = (d.root >> 1) + BitV;
            end else begin
                nxt.root = d.root >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q <= nxt;
        end
    end

endmodule

// ===== hdl/ddgps_speed.sv =====
`timescale 1ns / 1ps

// Wheel speed: truncating divide by 90 * 65536, saturate, turn-only select
module ddgps_speed
    import ddgps_pkg::*;
(
    input  logic                     aclk,
    input  logic                     en,
    input  logic signed [NW-1:0]     num,
    input  logic                     turn,
    input  logic signed [SpeedW-1:0] turn_v,
    output logic signed [SpeedW-1:0] speed
);

    localparam int UW = NW - 16;
    localparam int PW = UW + 15;

    logic [NW-1:0]     mag;
    logic [UW-1:0]     u_next;
    logic [UW-1:0]     u_reg;
    logic [PW-1:0]     prod_reg;
    logic              neg_reg;
    logic              turn_reg;
    logic signed [SpeedW-1:0] turn_v_reg;
    logic [UW-1:0]     q0;
    logic [UW-1:0]     q0x90;
    logic [UW-1:0]     r;
    logic [UW-1:0]     qv;
    logic [6:0]        sat;

    // stage A: magnitude, drop Q16, reciprocal multiply
    assign mag    = num[NW-1] ? NW'(-num) : NW'(num);
    assign u_next = mag[NW-1:16];

    always_ff @(posedge aclk) begin
        if (en) begin
            u_reg      <= u_next;
            prod_reg   <= PW'(u_next) * PW'(Recip90);
            neg_reg    <= num[NW-1];
            turn_reg   <= turn;
            turn_v_reg <= turn_v;
        end
    end

    // stage B: one correction step, saturate, restore sign
    assign q0    = UW'(prod_reg >> 21);
    assign q0x90 = (q0 << 6) + (q0 << 4) + (q0 << 3) + (q0 << 1);
    assign r     = u_reg - q0x90;
    assign qv    = (r >= UW'(90)) ? q0 + UW'(1) : q0;
    assign sat   = (qv > UW'(127)) ? 7'd127 : qv[6:0];

    always_comb begin
        if (turn_reg) begin
            speed = turn_v_reg;
        end else if (neg_reg) begin
            speed = -signed'({1'b0, sat});
        end else begin
            speed = signed'({1'b0, sat});
        end
    end

endmodule

// ===== hdl/diff_drive_goto_point_steering.sv =====
`timescale 1ns / 1ps

// Path to m_tdata: P0, P1, P2, CORDIC stages, Q0 to Q4, divide and output registers.
// Throughput: one transaction per cycle while not stalled; the depth is set by the
// 16-step CORDIC and 15-digit square root stages plus gain, multiply and divide stages.
// A stalled output freezes the whole pipeline; nothing is dropped.
// Reset (aresetn low, synchronous) empties the pipeline and sets cruise_speed to 70.
module diff_drive_goto_point_steering
    import ddgps_pkg::*;
#(
    parameter int SIGMOID_TABLE_DEPTH = SigDepthDefault
) (
    input  logic                aclk,
    input  logic                aresetn,
    // config: cruise_speed
    input  logic                cfg_wr_en,
    input  logic [6:0]          cfg_wr_data,
    // tdata: target_x[13:0], target_y[27:14], robot_x[41:28], robot_y[55:42],
    //        robot_heading[65:56], zero pad[71:66]
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [InDataW-1:0]  s_tdata,
    // tdata: left_speed[7:0], right_speed[15:8]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OutDataW-1:0] m_tdata
);

    localparam int IW = $clog2(SIGMOID_TABLE_DEPTH);
    localparam logic [IW-1:0] IdxMax = IW'(SIGMOID_TABLE_DEPTH - 1);

    logic adv;
    logic [6:0] cruise_reg;

    // Sigmoid table
    logic [16:0] sig_rom [SIGMOID_TABLE_DEPTH];
    for (genvar g = 0; g < SIGMOID_TABLE_DEPTH; g++) begin : g_rom
        localparam logic [16:0] V = sig_entry(g);
        assign sig_rom[g] = V;
    end

    // Pipeline advances whenever the output register can take data
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cruise_reg <= CruiseReset;
        end else if (cfg_wr_en) begin
            cruise_reg <= cfg_wr_data;
        end
    end

    // ---------------- P0: differences ----------------
    logic signed [DW-1:0]    dx_next, dy_next, dx_reg, dy_reg;
    logic signed [HeadW-1:0] hd0_reg;
    logic                    p0_v_reg;

    assign dx_next = signed'({s_tdata[13], s_tdata[13:0]}) -
                     signed'({s_tdata[41], s_tdata[41:28]});
    assign dy_next = signed'({s_tdata[27], s_tdata[27:14]}) -
                     signed'({s_tdata[55], s_tdata[55:42]});

    always_ff @(posedge aclk) begin
        if (adv) begin
            dx_reg  <= dx_next;
            dy_reg  <= dy_next;
            hd0_reg <= signed'(s_tdata[65:56]);
        end
    end

    // ---------------- P1: squares, special bearings ----------------
    logic [AbsW-1:0]         ax, ay, ax_reg, ay_reg;
    logic [SqW-1:0]          sqx_reg, sqy_reg;
    logic signed [HeadW-1:0] hd1_reg;
    logic                    dxn1_reg, dyn1_reg, org1_reg, frc1_reg;
    logic [6:0]              fdeg1_reg;
    logic                    p1_v_reg;
    logic                    frc_next;
    logic [6:0]              fdeg_next;

    assign ax = dx_reg[DW-1] ? AbsW'(-dx_reg) : AbsW'(dx_reg);
    assign ay = dy_reg[DW-1] ? AbsW'(-dy_reg) : AbsW'(dy_reg);

    always_comb begin
        frc_next  = 1'b1;
        fdeg_next = 7'd0;
        if (dy_reg == '0) begin
            fdeg_next = 7'd0;
        end else if (dx_reg == '0) begin
            fdeg_next = 7'd90;
        end else if (ax == ay) begin
            fdeg_next = 7'd45;
        end else begin
            frc_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ax_reg    <= ax;
            ay_reg    <= ay;
            sqx_reg   <= SqW'(ax) * SqW'(ax);
            sqy_reg   <= SqW'(ay) * SqW'(ay);
            hd1_reg   <= hd0_reg;
            dxn1_reg  <= dx_reg[DW-1];
            dyn1_reg  <= dy_reg[DW-1];
            org1_reg  <= (dx_reg == '0) && (dy_reg == '0);
            frc1_reg  <= frc_next;
            fdeg1_reg <= fdeg_next;
        end
    end

    // ---------------- P2: distance squared, CORDIC start ----------------
    iter_t it_s [CordicSteps+1];
    iter_t it0_next;
    iter_t it0_reg;
    logic  it_v_reg [CordicSteps+1];

    always_comb begin
        it0_next.x          = signed'(CW'({ax_reg, 16'h0000}));
        it0_next.y          = signed'(CW'({ay_reg, 16'h0000}));
        it0_next.a          = '0;
        it0_next.rem        = D2W'(sqx_reg) + D2W'(sqy_reg);
        it0_next.root       = '0;
        it0_next.d2         = D2W'(sqx_reg) + D2W'(sqy_reg);
        it0_next.heading    = hd1_reg;
        it0_next.dx_neg     = dxn1_reg;
        it0_next.dy_neg     = dyn1_reg;
        it0_next.at_origin  = org1_reg;
        it0_next.force_a    = frc1_reg;
        it0_next.forced_deg = fdeg1_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            it0_reg <= it0_next;
        end
    end

    assign it_s[0] = it0_reg;

    // ---------------- CORDIC and square root stages ----------------
    for (genvar k = 0; k < CordicSteps; k++) begin : g_iter
        ddgps_iter #(.STEP(k)) u_iter (
            .aclk (aclk),
            .en   (adv),
            .d    (it_s[k]),
            .q    (it_s[k+1])
        );
    end

    // ---------------- Q0: bearing, table index, gain band ----------------
    iter_t                   itf;
    logic signed [AW-1:0]    a_c;
    logic [6:0]              qdeg;
    logic                    frac;
    logic [7:0]              mag;
    logic signed [8:0]       brg_next, brg_reg;
    logic [IW-1:0]           idx_next, idx_reg;
    logic [4:0]              nb_next, nb0_reg;
    logic                    near0_reg;
    logic signed [HeadW-1:0] hd2_reg;
    logic                    q0_v_reg;

    assign itf = it_s[CordicSteps];

    always_comb begin
        if (itf.a < 0) begin
            a_c = '0;
        end else if (itf.a > signed'(AW'(90 << 16))) begin
            a_c = signed'(AW'(90 << 16));
        end else begin
            a_c = itf.a;
        end
        if (itf.force_a) begin
            qdeg = itf.forced_deg;
            frac = 1'b0;
        end else begin
            qdeg = a_c[22:16];
            frac = |a_c[15:0];
        end
        if (!itf.dx_neg) begin
            mag = {1'b0, qdeg};
        end else if (frac) begin
            mag = 8'd179 - {1'b0, qdeg};
        end else begin
            mag = 8'd180 - {1'b0, qdeg};
        end
        if (itf.at_origin) begin
            brg_next = 9'sd90;
        end else if (itf.dy_neg) begin
            brg_next = -signed'({1'b0, mag});
        end else begin
            brg_next = signed'({1'b0, mag});
        end
        if (itf.root > D2W'(SIGMOID_TABLE_DEPTH - 1)) begin
            idx_next = IdxMax;
        end else begin
            idx_next = itf.root[IW-1:0];
        end
        if (itf.d2 > D2Band100) begin
            nb_next = GainFar;
        end else if (itf.d2 > D2Band50) begin
            nb_next = Gain100;
        end else if (itf.d2 > D2Band30) begin
            nb_next = Gain50;
        end else if (itf.d2 > D2Band20) begin
            nb_next = Gain30;
        end else begin
            nb_next = GainClose;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            brg_reg   <= brg_next;
            idx_reg   <= idx_next;
            nb0_reg   <= nb_next;
            near0_reg <= itf.d2 < D2Near;
            hd2_reg   <= itf.heading;
        end
    end

    // ---------------- Q1: heading error wrap, table read ----------------
    logic signed [10:0] e0, e1, e2, e3, e4;
    logic signed [8:0]  err_reg;
    logic [16:0]        sig_reg;
    logic [4:0]         nb1_reg;
    logic               near1_reg;
    logic               q1_v_reg;

    always_comb begin
        e0 = 11'(brg_reg) - 11'(hd2_reg);
        e1 = (e0 > 11'sd180) ? e0 - 11'sd360 : e0;
        e2 = (e1 > 11'sd180) ? e1 - 11'sd360 : e1;
        e3 = (e2 < -11'sd180) ? e2 + 11'sd360 : e2;
        e4 = (e3 < -11'sd180) ? e3 + 11'sd360 : e3;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            err_reg   <= e4[8:0];
            sig_reg   <= sig_rom[idx_reg];
            nb1_reg   <= nb0_reg;
            near1_reg <= near0_reg;
        end
    end

    // ---------------- Q2: drive mode, gain, cruise product ----------------
    logic               rev, turn;
    logic signed [9:0]  t0, t1;
    logic signed [8:0]  err2;
    logic [7:0]         aerr2;
    logic [8:0]         aerr;
    logic [10:0]        t17;
    logic [4:0]         tmag;
    logic signed [17:0] sdiff;
    logic signed [25:0] base1_reg;
    logic signed [8:0]  err2_reg;
    logic [4:0]         n_reg;
    logic               rev_reg, turn2_reg;
    logic signed [SpeedW-1:0] tr_reg, tl_reg;
    logic               q2_v_reg;

    assign rev  = (err_reg > 9'sd95) || (err_reg < -9'sd95);
    assign turn = !rev && ((err_reg >= 9'sd85) || (err_reg <= -9'sd85));

    always_comb begin
        t0 = 10'(err_reg) + 10'sd180;
        t1 = (t0 > 10'sd180) ? t0 - 10'sd360 : t0;
        if (!rev) begin
            err2 = err_reg;
        end else if (t1 > 10'sd80) begin
            err2 = 9'sd80;
        end else if (t1 < -10'sd80) begin
            err2 = -9'sd80;
        end else begin
            err2 = t1[8:0];
        end
        aerr2 = err2[8] ? 8'(-err2) : 8'(err2);
        aerr  = err_reg[8] ? 9'(-err_reg) : 9'(err_reg);
        // turn in place: 17 * err / 100, error within 85..95
        t17   = 11'(aerr) * 11'd17;
        tmag  = 5'd14 + 5'(t17 >= 11'd1500) + 5'(t17 >= 11'd1600);
    end

    assign sdiff = signed'({1'b0, sig_reg}) - signed'({1'b0, OffsetQ16});

    always_ff @(posedge aclk) begin
        if (adv) begin
            base1_reg <= 26'(signed'({1'b0, cruise_reg})) * 26'(sdiff);
            err2_reg  <= err2;
            n_reg     <= (near1_reg && aerr2 < 8'd40) ? GainNear : nb1_reg;
            rev_reg   <= rev;
            turn2_reg <= turn;
            tr_reg    <= err_reg[8] ? -signed'({3'b000, tmag}) : signed'({3'b000, tmag});
            tl_reg    <= err_reg[8] ? signed'({3'b000, tmag}) : -signed'({3'b000, tmag});
        end
    end

    // ---------------- Q3: times 90, gain times error ----------------
    logic signed [32:0] b33, base90;
    logic signed [NW-1:0] base90_reg;
    logic signed [13:0] ne_reg;
    logic               turn3_reg;
    logic signed [SpeedW-1:0] tr3_reg, tl3_reg;
    logic               q3_v_reg;

    assign b33    = 33'(base1_reg);
    assign base90 = (b33 <<< 6) + (b33 <<< 4) + (b33 <<< 3) + (b33 <<< 1);

    always_ff @(posedge aclk) begin
        if (adv) begin
            base90_reg <= rev_reg ? -NW'(base90) : NW'(base90);
            ne_reg     <= 14'(signed'({1'b0, n_reg})) * 14'(err2_reg);
            turn3_reg  <= turn2_reg;
            tr3_reg    <= tr_reg;
            tl3_reg    <= tl_reg;
        end
    end

    // ---------------- Q4: wheel numerators ----------------
    logic signed [NW-1:0] ne_sh;
    logic signed [NW-1:0] nr_reg, nl_reg;
    logic               turn4_reg;
    logic signed [SpeedW-1:0] tr4_reg, tl4_reg;
    logic               q4_v_reg;
    logic               a_v_reg;

    assign ne_sh = NW'(ne_reg) <<< 16;

    always_ff @(posedge aclk) begin
        if (adv) begin
            nr_reg    <= base90_reg + ne_sh;
            nl_reg    <= base90_reg - ne_sh;
            turn4_reg <= turn3_reg;
            tr4_reg   <= tr3_reg;
            tl4_reg   <= tl3_reg;
        end
    end

    // ---------------- divide and saturate, output register ----------------
    logic signed [SpeedW-1:0] left_v, right_v;

    ddgps_speed u_left (
        .aclk   (aclk),
        .en     (adv),
        .num    (nl_reg),
        .turn   (turn4_reg),
        .turn_v (tl4_reg),
        .speed  (left_v)
    );

    ddgps_speed u_right (
        .aclk   (aclk),
        .en     (adv),
        .num    (nr_reg),
        .turn   (turn4_reg),
        .turn_v (tr4_reg),
        .speed  (right_v)
    );

    logic [OutDataW-1:0] m_tdata_reg;
    logic                m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= {right_v, left_v};
        end
    end

    // ---------------- valid chain ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p0_v_reg     <= 1'b0;
            p1_v_reg     <= 1'b0;
            q0_v_reg     <= 1'b0;
            q1_v_reg     <= 1'b0;
            q2_v_reg     <= 1'b0;
            q3_v_reg     <= 1'b0;
            q4_v_reg     <= 1'b0;
            a_v_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i <= CordicSteps; i++) begin
                it_v_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            p0_v_reg    <= s_tvalid;
            p1_v_reg    <= p0_v_reg;
            it_v_reg[0] <= p1_v_reg;
            for (int i = 1; i <= CordicSteps; i++) begin
                it_v_reg[i] <= it_v_reg[i-1];
            end
            q0_v_reg     <= it_v_reg[CordicSteps];
            q1_v_reg     <= q0_v_reg;
            q2_v_reg     <= q1_v_reg;
            q3_v_reg     <= q2_v_reg;
            q4_v_reg     <= q3_v_reg;
            a_v_reg      <= q4_v_reg;
            m_tvalid_reg <= a_v_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------- assertions ----------------
    a_brg_range: assert property (@(posedge aclk) disable iff (!aresetn)
        q0_v_reg |-> (brg_reg <= 9'sd180) && (brg_reg >= -9'sd180))
        else $error("bearing outside +-180");

    a_err_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        q1_v_reg |-> (err_reg <= 9'sd180) && (err_reg >= -9'sd180))
        else $error("heading error not wrapped");

    a_err2_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (q2_v_reg && !turn2_reg) |-> (err2_reg < 9'sd85) && (err2_reg > -9'sd85))
        else $error("drive error outside steering band");

    a_out_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:0] != 8'h80) && (m_tdata[15:8] != 8'h80))
        else $error("wheel speed not saturated");

endmodule

// ===== tb/diff_drive_goto_point_steering_chk.sv =====
`timescale 1ns / 1ps

module diff_drive_goto_point_steering_chk
    import ddgps_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [6:0]          cfg_wr_data,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [InDataW-1:0]  s_tdata,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [OutDataW-1:0] m_tdata,
    output int                  pending,
    output int                  fail_count
);

    localparam int RomDepth = 256;

    typedef struct packed {
        logic signed [SpeedW-1:0] left;
        logic signed [SpeedW-1:0] right;
    } wheels_t;

    longint unsigned sigmoid_rom [RomDepth];
    logic [6:0]      cruise;
    wheels_t         wheel_queue [$];

    // sigmoid(3 * i / 64) in Q16, same recurrence as the hardware ROM
    initial begin
        longint unsigned e;
        e = 64'd1 << 30;
        for (int i = 0; i < RomDepth; i++) begin
            sigmoid_rom[i] = (64'd1 << 46) / ((64'd1 << 30) + e);
            e = (e * 64'd1024571606 + (64'd1 << 29)) >> 30;
        end
    end

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 30;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Bearing in whole degrees, truncated toward zero
    function automatic longint bearing_deg(longint dx, longint dy);
        longint ax, ay, a, q, mag, x, y, nx, ny;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        if (dx == 0 && dy == 0) return 90;
        if (dy == 0) begin
            a = 0;
        end else if (dx == 0) begin
            a = 90 * 65536;
        end else if (ax == ay) begin
            a = 45 * 65536;
        end else begin
            x = ax * 65536;
            y = ay * 65536;
            a = 0;
            for (int i = 0; i < CordicSteps; i++) begin
                if (y > 0) begin
                    nx = x + (y >>> i);
                    ny = y - (x >>> i);
                    a  = a + longint'(ATAN_Q16[i]);
                end else begin
                    nx = x - (y >>> i);
                    ny = y + (x >>> i);
                    a  = a - longint'(ATAN_Q16[i]);
                end
                x = nx;
                y = ny;
            end
            if (a < 0) a = 0;
            if (a > 90 * 65536) a = 90 * 65536;
        end
        q = a / 65536;
        if (dx >= 0) mag = q;
        else mag = (a % 65536 != 0) ? 179 - q : 180 - q;
        return (dy < 0) ? -mag : mag;
    endfunction

    function automatic longint clip127(longint v);
        if (v > 127) return 127;
        if (v < -127) return -127;
        return v;
    endfunction

    function automatic wheels_t predict_wheels(logic [InDataW-1:0] cmd, logic [6:0] vc);
        longint dx, dy, hd, err, n, base, vl, vr, abserr;
        longint unsigned d2, idx;
        wheels_t w;
        dx  = longint'($signed(cmd[13:0])) - longint'($signed(cmd[41:28]));
        dy  = longint'($signed(cmd[27:14])) - longint'($signed(cmd[55:42]));
        hd  = longint'($signed(cmd[65:56]));
        d2  = dx * dx + dy * dy;
        err = bearing_deg(dx, dy) - hd;
        while (err > 180) err = err - 360;
        while (err < -180) err = err + 360;

        // turn gain from distance bands
        if (d2 > 6400 * 6400) n = 17;
        else if (d2 > 3200 * 3200) n = 19;
        else if (d2 > 1920 * 1920) n = 21;
        else if (d2 > 1280 * 1280) n = 23;
        else n = 25;

        idx = int_sqrt(d2);
        if (idx > RomDepth - 1) idx = RomDepth - 1;

        if (err > 95 || err < -95 || (err < 85 && err > -85)) begin
            base = longint'(vc) * (longint'(sigmoid_rom[idx]) - 19661) * 90;
            // reverse drive
            if (err > 95 || err < -95) begin
                err = err + 180;
                if (err > 180) err = err - 360;
                if (err > 80) err = 80;
                if (err < -80) err = -80;
                base = -base;
            end
            abserr = (err < 0) ? -err : err;
            if (d2 < 320 * 320 && abserr < 40) n = 9;
            vr = (base + n * err * 65536) / 5898240;
            vl = (base - n * err * 65536) / 5898240;
        end else begin
            // turn in place
            vr = (17 * err) / 100;
            vl = -vr;
        end
        w.left  = clip127(vl);
        w.right = clip127(vr);
        return w;
    endfunction

    assign pending = wheel_queue.size();

    // Track config, predict accepted commands, compare results
    always @(posedge aclk) begin
        wheels_t want;
        int      errs;
        errs = 0;
        if (!aresetn) begin
            cruise <= CruiseReset;
            wheel_queue.delete();
        end else begin
            if (cfg_wr_en) cruise <= cfg_wr_data;
            if (s_tvalid && s_tready) wheel_queue.push_back(predict_wheels(s_tdata, cruise));
            if (m_tvalid && m_tready) begin
                if (wheel_queue.size() == 0) begin
                    $error("unexpected result transaction %h", m_tdata);
                    errs = errs + 1;
                end else begin
                    want = wheel_queue.pop_front();
                    if (m_tdata[7:0] !== want.left) begin
                        $error("left_speed: expected %0d, got %0d",
                               want.left, $signed(m_tdata[7:0]));
                        errs = errs + 1;
                    end
                    if (m_tdata[15:8] !== want.right) begin
                        $error("right_speed: expected %0d, got %0d",
                               want.right, $signed(m_tdata[15:8]));
                        errs = errs + 1;
                    end
                end
            end
            if (errs != 0) fail_count <= fail_count + errs;
        end
    end

    initial fail_count = 0;

endmodule

// ===== tb/diff_drive_goto_point_steering_test.sv =====
`timescale 1ns / 1ps

module diff_drive_goto_point_steering_test;
    import ddgps_pkg::*;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [6:0]          cfg_wr_data = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [InDataW-1:0]  s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OutDataW-1:0] m_tdata;
    int                  pending;
    int                  fail_count;
    bit                  send_gaps = 1'b1;
    bit                  recv_gaps = 1'b1;
    bit                  hold_request = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    diff_drive_goto_point_steering uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    diff_drive_goto_point_steering_chk chk (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .pending(pending), .fail_count(fail_count)
    );

    // Offer one command transaction and wait until it is taken
    task automatic send_cmd(int tx, int ty, int rx, int ry, int hd);
        int gap;
        gap = send_gaps ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= {6'd0, hd[9:0], ry[13:0], rx[13:0], ty[13:0], tx[13:0]};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (30) @(negedge aclk);
    endtask

    task automatic write_cruise(logic [6:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic int rnd_pos();
        return int'($urandom_range(0, 16383)) - 8192;
    endfunction

    task automatic random_cmds(int count);
        int tx, ty, rx, ry, hd, off, mode;
        for (int i = 0; i < count; i++) begin
            mode = $urandom_range(0, 9);
            tx = rnd_pos();
            ty = rnd_pos();
            off = (mode < 3) ? 400 : (mode < 5) ? 40 : 8191;
            rx = tx + int'($urandom_range(0, 2 * off)) - off;
            ry = ty + int'($urandom_range(0, 2 * off)) - off;
            if (rx > 8191 || rx < -8192) rx = rnd_pos();
            if (ry > 8191 || ry < -8192) ry = rnd_pos();
            if (mode == 5) ry = ty;                 // on the x axis
            if (mode == 6) rx = tx;                 // on the y axis
            if (mode == 7 && tx - (ty - ry) <= 8191 && tx - (ty - ry) >= -8192)
                rx = tx - (ty - ry);                // on a diagonal
            hd = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 1023)) - 512
                                             : int'($urandom_range(0, 720)) - 360;
            send_cmd(tx, ty, rx, ry, hd);
        end
    endtask

    // Receiver: random back-pressure, plus one long hold on request
    initial begin
        int gap;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                gap = 300;
                hold_request = 1'b0;
            end else begin
                gap = recv_gaps ? $urandom_range(0, 15) : 0;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: extremes, zero distance, axes, diagonals, heading wrap, far and near
        send_cmd(0, 0, 0, 0, 0);
        send_cmd(100, 100, 100, 100, 90);
        send_cmd(8191, 8191, -8192, -8192, 0);
        send_cmd(-8192, -8192, 8191, 8191, 360);
        send_cmd(8191, -8192, -8192, 8191, -360);
        send_cmd(-8192, 8191, 8191, -8192, 511);
        send_cmd(1000, 0, 0, 0, -512);
        send_cmd(-1000, 0, 0, 0, 0);
        send_cmd(0, 1000, 0, 0, 0);
        send_cmd(0, -1000, 0, 0, 90);
        send_cmd(500, 500, 0, 0, 45);
        send_cmd(-500, -500, 0, 0, 45);
        send_cmd(30, 10, 0, 0, 10);
        send_cmd(10, 30, 0, 0, -20);
        send_cmd(200, 0, 0, 0, 90);
        send_cmd(200, 0, 0, 0, -88);
        send_cmd(200, 0, 0, 0, 95);
        send_cmd(200, 0, 0, 0, 96);
        send_cmd(-200, 3, 0, 0, 0);
        send_cmd(3000, 4000, 0, 0, 180);
        send_cmd(7000, 100, -1000, 0, -179);
        send_cmd(-8192, 0, 8191, 0, 1);
        drain();

        // Cruise speed phases, extremes first
        write_cruise(7'd0);
        random_cmds(300);
        drain();
        write_cruise(7'd127);
        recv_gaps = 1'b0;
        send_gaps = 1'b0;
        random_cmds(300);
        recv_gaps = 1'b1;
        send_gaps = 1'b1;
        drain();
        write_cruise(7'd70);
        random_cmds(400);

        // Long receiver hold while commands keep coming
        hold_request = 1'b1;
        send_gaps = 1'b0;
        random_cmds(200);
        send_gaps = 1'b1;
        drain();
        for (int p = 0; p < 4; p++) begin
            write_cruise(7'($urandom_range(0, 127)));
            random_cmds(200);
            drain();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
